FILE: rtl/core/hws_pkg.sv
// Shared types, constants and saturation helper for the heightfield wave step block.
`timescale 1ns / 1ps
package hws_pkg;
	localparam int MAX_ROWS_DEF    = 63;
	localparam int MAX_COLS_DEF    = 63;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int WIDE_W          = 72;

	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 40;

	localparam logic [5:0]  ROWS_RST = 6'd63;
	localparam logic [5:0]  COLS_RST = 6'd63;
	localparam logic [15:0] GAIN_RST = 16'd1024;
	localparam logic [15:0] DAMP_RST = 16'd64881;

	typedef enum logic [1:0] {
		OP_STEP  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_ROWS = 2'd0,
		REG_COLS = 2'd1,
		REG_GAIN = 2'd2,
		REG_DAMP = 2'd3
	} reg_idx_t;

	// Coefficients handed to the point datapath
	typedef struct packed {
		logic [15:0] gain;
		logic [15:0] damp;
		logic [15:0] dt;
	} coef_t;

	// Clamp a wide signed value to a signed range of the given width
	function automatic logic signed [WIDE_W-1:0] sat_val(
		input logic signed [WIDE_W-1:0] x,
		input int unsigned bits
	);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = $signed((WIDE_W'(1) << (bits - 1)) - WIDE_W'(1));
		lo = -hi - WIDE_W'(1);
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction
endpackage

FILE: rtl/core/heightfield_wave_step.sv
// Top level of the heightfield wave step block: sequencer, stores and stream ports.
`timescale 1ns / 1ps
// Keeps a grid of Q16.16 heights and velocities in on-chip memories. After reset the
// block clears every entry of both stores, one entry per cycle (4096 entries at the
// default 64 by 64 storage), and takes no request meanwhile. A read or write request
// passes through its own state and then the response state. A step request sweeps
// every active point: five height reads through the single read port of the height
// memory feed the six-stage point datapath for each point in turn, then a commit pass
// copies new heights back at one point per cycle. One request is in work at a time; a
// finished result waits in the output register while the next request is taken.
module heightfield_wave_step #(
	parameter int MAX_ROWS    = hws_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS    = hws_pkg::MAX_COLS_DEF,
	parameter int VALUE_WIDTH = hws_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// operation[1:0], row[7:2], col[13:8], height_in[45:14], time_step[61:46], zeros
	input  logic [hws_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// height_out[31:0], done_operation[33:32], zeros
	output logic [hws_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data
);
	import hws_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int AW = RW + CW;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RD, ST_WR, ST_PT, ST_CALC, ST_COMMIT, ST_DRAIN, ST_RESP
	} state_t;

	state_t state_q;
	logic [5:0]  rows_q, cols_q;
	logic [15:0] gain_q, damp_q;
	logic [1:0]  op_q;
	logic [5:0]  row_q, col_q;
	logic [31:0] hin_q;
	logic [15:0] dt_q;
	logic [RW-1:0] r_q, cr_q;
	logic [CW-1:0] c_q, cc_q;
	logic [2:0]  ph_q;
	logic signed [W-1:0] u_q, vel_q;
	logic signed [W+1:0] nsum_q, nsum_fin;
	logic [AW-1:0] clr_q, cm_addr_s1;
	logic cm_v_s1;
	logic m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [RW-1:0] rmax, cell_r, up_r, dn_r;
	logic [CW-1:0] cmax, cell_c, lf_c, rt_c;
	logic [AW-1:0] k_addr, cell_addr;

	logic          h_we, v_we, n_we;
	logic [AW-1:0] h_waddr, h_raddr;
	logic [W-1:0]  h_wdata, h_rdata, v_rdata, n_rdata;
	logic          dp_done, dp_start;
	logic signed [W-1:0] dp_v, dp_h;
	coef_t         coef;
	logic signed [WIDE_W-1:0] hin_sat, rd_sat;

	// active grid bounds and clamped addresses
	always_comb begin
		rmax   = (32'(rows_q) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_q);
		cmax   = (32'(cols_q) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_q);
		cell_r = (32'(row_q) > 32'(rmax)) ? rmax : RW'(row_q);
		cell_c = (32'(col_q) > 32'(cmax)) ? cmax : CW'(col_q);
		up_r   = (r_q == '0) ? r_q : r_q - RW'(1);
		dn_r   = (r_q == rmax) ? r_q : r_q + RW'(1);
		lf_c   = (c_q == '0) ? c_q : c_q - CW'(1);
		rt_c   = (c_q == cmax) ? c_q : c_q + CW'(1);
		k_addr    = {r_q, c_q};
		cell_addr = {cell_r, cell_c};
	end

	// height read address follows the neighbour phase during a sweep
	always_comb begin
		h_raddr = cell_addr;
		if (state_q == ST_PT) begin
			case (ph_q)
				3'd0:    h_raddr = k_addr;
				3'd1:    h_raddr = {up_r, c_q};
				3'd2:    h_raddr = {dn_r, c_q};
				3'd3:    h_raddr = {r_q, lf_c};
				3'd4:    h_raddr = {r_q, rt_c};
				default: h_raddr = k_addr;
			endcase
		end
	end

	// write port steering
	always_comb begin
		hin_sat = sat_val(WIDE_W'($signed(hin_q)), W);
		rd_sat  = sat_val(WIDE_W'($signed(h_rdata)), 32);
		h_we    = 1'b0;
		h_waddr = cell_addr;
		h_wdata = hin_sat[W-1:0];
		if (state_q == ST_CLEAR) begin
			h_we    = 1'b1;
			h_waddr = clr_q;
			h_wdata = '0;
		end else if (state_q == ST_WR) begin
			h_we = 1'b1;
		end else if (cm_v_s1) begin
			h_we    = 1'b1;
			h_waddr = cm_addr_s1;
			h_wdata = n_rdata;
		end
		v_we     = (state_q == ST_CLEAR) || dp_done;
		n_we     = dp_done;
		nsum_fin = nsum_q + (W+2)'($signed(h_rdata));
		dp_start = (state_q == ST_PT) && (ph_q == 3'd5);
		coef     = '{gain: gain_q, damp: damp_q, dt: dt_q};
	end

	hws_mem #(.AW(AW), .DW(W)) u_height (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	hws_mem #(.AW(AW), .DW(W)) u_velocity (
		.clk(clk), .we(v_we),
		.waddr((state_q == ST_CLEAR) ? clr_q : k_addr),
		.wdata((state_q == ST_CLEAR) ? '0 : dp_v),
		.raddr(k_addr), .rdata(v_rdata)
	);

	hws_mem #(.AW(AW), .DW(W)) u_next (
		.clk(clk), .we(n_we), .waddr(k_addr), .wdata(dp_h),
		.raddr({cr_q, cc_q}), .rdata(n_rdata)
	);

	hws_point #(.VALUE_WIDTH(W)) u_point (
		.clk(clk), .arst_n(arst_n), .start(dp_start), .coef(coef),
		.nsum(nsum_fin), .u(u_q), .vel(vel_q),
		.done(dp_done), .v_new(dp_v), .h_new(dp_h)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RST;
			cols_q <= COLS_RST;
			gain_q <= GAIN_RST;
			damp_q <= DAMP_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ROWS: rows_q <= cfg_data[5:0];
				REG_COLS: cols_q <= cfg_data[5:0];
				REG_GAIN: gain_q <= cfg_data;
				REG_DAMP: damp_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			r_q        <= '0;
			c_q        <= '0;
			cr_q       <= '0;
			cc_q       <= '0;
			ph_q       <= '0;
			cm_v_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			cm_v_s1 <= 1'b0;
			if (m_tvalid_q && m_tready && state_q != ST_RESP)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q  <= s_tdata[1:0];
						row_q <= s_tdata[7:2];
						col_q <= s_tdata[13:8];
						hin_q <= s_tdata[45:14];
						dt_q  <= s_tdata[61:46];
						r_q   <= '0;
						c_q   <= '0;
						ph_q  <= '0;
						case (op_t'(s_tdata[1:0]))
							OP_STEP:  state_q <= ST_PT;
							OP_WRITE: state_q <= ST_WR;
							OP_READ:  state_q <= ST_RD;
							default:  state_q <= ST_RESP;
						endcase
					end
				end
				ST_RD, ST_WR: state_q <= ST_RESP;
				ST_PT: begin
					ph_q <= ph_q + 3'd1;
					case (ph_q)
						3'd1: begin
							u_q    <= $signed(h_rdata);
							vel_q  <= $signed(v_rdata);
							nsum_q <= '0;
						end
						3'd2, 3'd3, 3'd4: nsum_q <= nsum_fin;
						3'd5: state_q <= ST_CALC;
						default: ;
					endcase
				end
				ST_CALC: begin
					if (dp_done) begin
						ph_q <= '0;
						if (c_q == cmax) begin
							c_q <= '0;
							if (r_q == rmax) begin
								cr_q    <= '0;
								cc_q    <= '0;
								state_q <= ST_COMMIT;
							end else begin
								r_q     <= r_q + RW'(1);
								state_q <= ST_PT;
							end
						end else begin
							c_q     <= c_q + CW'(1);
							state_q <= ST_PT;
						end
					end
				end
				ST_COMMIT: begin
					cm_v_s1    <= 1'b1;
					cm_addr_s1 <= {cr_q, cc_q};
					if (cc_q == cmax) begin
						cc_q <= '0;
						if (cr_q == rmax)
							state_q <= ST_DRAIN;
						else
							cr_q <= cr_q + RW'(1);
					end else begin
						cc_q <= cc_q + CW'(1);
					end
				end
				ST_DRAIN: state_q <= ST_RESP;
				ST_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'd0, op_q,
							(op_t'(op_q) == OP_READ) ? rd_sat[31:0] : 32'd0};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// datapath results arrive only while the sequencer waits for them
	a_dp_done: assert property (@(posedge clk) disable iff (!arst_n)
		dp_done |-> state_q == ST_CALC) else $error("point result outside calc");

	// commit writes follow commit address issue
	a_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cm_v_s1 |-> $past(state_q) == ST_COMMIT) else $error("stray commit write");

	// sweep position stays inside the active grid
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PT |-> (r_q <= rmax) && (c_q <= cmax)) else $error("sweep out of grid");
endmodule

FILE: rtl/core/hws_mem.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
`timescale 1ns / 1ps
module hws_mem #(
	parameter int AW = 12,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [(1 << AW)];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/hws_point.sv
// Six-stage fixed-point datapath that updates the velocity and height of one grid point.
`timescale 1ns / 1ps
module hws_point #(
	parameter int VALUE_WIDTH = hws_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  hws_pkg::coef_t                coef,
	input  logic signed [VALUE_WIDTH+1:0] nsum,
	input  logic signed [VALUE_WIDTH-1:0] u,
	input  logic signed [VALUE_WIDTH-1:0] vel,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] v_new,
	output logic signed [VALUE_WIDTH-1:0] h_new
);
	import hws_pkg::*;
	localparam int W = VALUE_WIDTH;

	// u and vel are held steady by the sequencer for the whole pass
	logic [5:0] vld_s;
	logic signed [W-1:0] d_s1, a_s2, i_s3, v_s4, v_s5;
	logic signed [W+16:0] p2, p3, p5;
	logic signed [WIDE_W-1:0] t1, t2, t3, t4, t5, t6;

	always_comb begin
		t1 = sat_val(WIDE_W'(nsum >>> 2) - WIDE_W'(u), W);
		p2 = d_s1 * $signed({1'b0, coef.gain});
		t2 = sat_val(WIDE_W'(p2 >>> 8), W);
		p3 = a_s2 * $signed({1'b0, coef.dt});
		t3 = sat_val(WIDE_W'(p3 >>> 16), W);
		t4 = sat_val(WIDE_W'(vel) + WIDE_W'(i_s3), W);
		p5 = v_s4 * $signed({1'b0, coef.damp});
		t5 = sat_val(WIDE_W'(p5 >>> 16), W);
		t6 = sat_val(WIDE_W'(u) + WIDE_W'(v_s5), W);
	end

	// advance the valid marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[4:0], start};
	end

	// arithmetic stages
	always_ff @(posedge clk) begin
		d_s1  <= t1[W-1:0];
		a_s2  <= t2[W-1:0];
		i_s3  <= t3[W-1:0];
		v_s4  <= t4[W-1:0];
		v_s5  <= t5[W-1:0];
		v_new <= v_s5;
		h_new <= t6[W-1:0];
	end

	assign done = vld_s[5];
endmodule

FILE: tb/hws_checker.sv
// Checker for the heightfield wave step block: watches requests, predicts, compares results.
`timescale 1ns / 1ps
module hws_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [hws_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [hws_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data,
	output int                            failures,
	output int                            pending,
	output int                            steps_done,
	output int                            reads_done
);
	import hws_pkg::*;

	localparam int STRIDE = MAX_COLS_DEF + 1;
	localparam int DEPTH  = (MAX_ROWS_DEF + 1) * STRIDE;

	typedef struct {
		logic [31:0] height;
		op_t         op;
	} cell_result_t;

	// Shadow copy of the grid and of the registers
	longint       surface[DEPTH];
	longint       speed[DEPTH];
	longint       staged[DEPTH];
	logic [5:0]   rows_q;
	logic [5:0]   cols_q;
	logic [15:0]  gain_q;
	logic [15:0]  damp_q;
	cell_result_t expected_results[$];

	initial begin
		for (int k = 0; k < DEPTH; k++) begin
			surface[k] = 0;
			speed[k] = 0;
		end
		rows_q = ROWS_RST;
		cols_q = COLS_RST;
		gain_q = GAIN_RST;
		damp_q = DAMP_RST;
		failures = 0;
		pending = 0;
		steps_done = 0;
		reads_done = 0;
	end

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	// Scale by an unsigned factor, floor the shift, saturate
	function automatic longint scale_floor(longint x, int unsigned k, int unsigned s);
		longint p;
		p = x * longint'(k);
		return sat32(p >>> s);
	endfunction

	function automatic int cell_index(int r, int c);
		int rr;
		int cc;
		rr = (r < 0) ? 0 : ((r > int'(rows_q)) ? int'(rows_q) : r);
		cc = (c < 0) ? 0 : ((c > int'(cols_q)) ? int'(cols_q) : c);
		return rr * STRIDE + cc;
	endfunction

	// One full sweep of the active grid, committed at the end
	task automatic sweep_surface(input logic [15:0] dt);
		int     k;
		longint u;
		longint n;
		longint d;
		longint v;
		for (int r = 0; r <= int'(rows_q); r++) begin
			for (int c = 0; c <= int'(cols_q); c++) begin
				k = cell_index(r, c);
				u = surface[k];
				n = surface[cell_index(r - 1, c)] + surface[cell_index(r + 1, c)]
					+ surface[cell_index(r, c - 1)] + surface[cell_index(r, c + 1)];
				d = sat32((n >>> 2) - u);
				d = scale_floor(d, gain_q, 8);
				d = scale_floor(d, dt, 16);
				v = sat32(speed[k] + d);
				v = scale_floor(v, damp_q, 16);
				speed[k] = v;
				staged[k] = sat32(u + v);
			end
		end
		for (int r = 0; r <= int'(rows_q); r++)
			for (int c = 0; c <= int'(cols_q); c++)
				surface[cell_index(r, c)] = staged[cell_index(r, c)];
	endtask

	// Track register writes
	always @(posedge clk) begin
		if (arst_n && cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ROWS: rows_q = cfg_data[5:0];
				REG_COLS: cols_q = cfg_data[5:0];
				REG_GAIN: gain_q = cfg_data;
				REG_DAMP: damp_q = cfg_data;
				default: ;
			endcase
		end
	end

	// Predict on each request, then compare each result with the oldest prediction
	always @(posedge clk) begin
		op_t          op;
		cell_result_t want;
		cell_result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				op = op_t'(s_tdata[1:0]);
				want.op = op;
				want.height = '0;
				case (op)
					OP_STEP: begin
						sweep_surface(s_tdata[61:46]);
						steps_done++;
					end
					OP_WRITE: surface[cell_index(s_tdata[7:2], s_tdata[13:8])] =
						longint'($signed(s_tdata[45:14]));
					OP_READ: begin
						want.height = 32'(surface[cell_index(s_tdata[7:2], s_tdata[13:8])]);
						reads_done++;
					end
					default: ;
				endcase
				expected_results.insert(expected_results.size(), want);
			end
			if (m_tvalid && m_tready) begin
				got.height = m_tdata[31:0];
				got.op = op_t'(m_tdata[33:32]);
				if (expected_results.size() == 0) begin
					$error("result with none expected: height_out %h done_operation %0d",
						got.height, got.op);
					failures++;
				end else begin
					want = expected_results.pop_front();
					if (got.height !== want.height) begin
						$error("height_out: expected %h actual %h", want.height, got.height);
						failures++;
					end
					if (got.op !== want.op) begin
						$error("done_operation: expected %0d actual %0d", want.op, got.op);
						failures++;
					end
				end
			end
			pending = expected_results.size();
		end
	end
endmodule

FILE: tb/tb_top.sv
// Testbench top for the heightfield wave step block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;
	import hws_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// operation[1:0], row[7:2], col[13:8], height_in[45:14], time_step[61:46], zeros
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	// height_out[31:0], done_operation[33:32], zeros
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_we;
	logic [1:0]           cfg_index;
	logic [15:0]          cfg_data;

	int failures;
	int pending;
	int steps_done;
	int reads_done;
	int send_idle_pct;
	int recv_stall_pct;
	bit holdoff_go;
	int holdoff_left;
	int sent;

	heightfield_wave_step i_dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data
	);

	hws_checker i_checker (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data,
		.failures, .pending, .steps_done, .reads_done
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Generous limit: a few full-grid sweeps plus all small-grid traffic under stalls
	initial begin
		#4000000;
		$display("heightfield_wave_step regression: fail");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off counted here
	initial begin
		m_tready = 1'b0;
		holdoff_left = 400;
		forever begin
			@(negedge clk);
			if (holdoff_go && holdoff_left > 0) begin
				m_tready <= 1'b0;
				holdoff_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offer one request; entered and left at a falling edge
	task automatic send_request(input op_t op, input logic [5:0] row, input logic [5:0] col,
		input logic [31:0] height, input logic [15:0] dt);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, dt, height, col, row, op};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		sent++;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (20)
			@(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_grid(input logic [5:0] rows, input logic [5:0] cols,
		input logic [15:0] gain, input logic [15:0] damp);
		drain();
		write_reg(REG_ROWS, 16'(rows));
		write_reg(REG_COLS, 16'(cols));
		write_reg(REG_GAIN, gain);
		write_reg(REG_DAMP, damp);
	endtask

	function automatic logic [31:0] pick_height();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(32'h0003_FFFF);
			3: return -$urandom_range(32'h0003_FFFF);
			default: return $urandom;
		endcase
	endfunction

	// Mostly writes and reads around small grids, steps mixed in
	task automatic random_phase(input int count, input bit with_pauses);
		int   sel;
		op_t  op;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			op = (sel < 25) ? OP_STEP : (sel < 60) ? OP_WRITE : (sel < 92) ? OP_READ : OP_NONE;
			send_request(op, 6'($urandom_range(63)), 6'($urandom_range(63)), pick_height(),
				($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom));
			if (with_pauses && i % 10 == 9)
				drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ROWS;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holdoff_go = 1'b0;
		sent = 0;
		repeat (10)
			@(negedge clk);
		arst_n = 1'b1;
		// hold until the clearing pass ends
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);

		// Directed: edges of the fields on a small grid
		set_grid(6'd2, 6'd3, GAIN_RST, DAMP_RST);
		send_request(OP_READ, 6'd0, 6'd0, 32'h0, 16'h0);
		send_request(OP_WRITE, 6'd0, 6'd0, 32'h7FFF_FFFF, 16'h0);
		send_request(OP_WRITE, 6'd63, 6'd63, 32'h8000_0000, 16'hFFFF);
		send_request(OP_WRITE, 6'd1, 6'd2, 32'h0001_0000, 16'h0);
		send_request(OP_READ, 6'd0, 6'd0, 32'hFFFF_FFFF, 16'h0);
		send_request(OP_READ, 6'd2, 6'd3, 32'h0, 16'h0);
		send_request(OP_READ, 6'd0, 6'd63, 32'h0, 16'h0);
		send_request(OP_NONE, 6'd63, 6'd63, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(OP_STEP, 6'd0, 6'd0, 32'h0, 16'hFFFF);
		send_request(OP_STEP, 6'd0, 6'd0, 32'h0, 16'h0);
		for (int r = 0; r <= 2; r++)
			send_request(OP_READ, 6'(r), 6'(r + 1), 32'h0, 16'h0);
		// single-point grid acts as its own neighbour
		set_grid(6'd0, 6'd0, 16'hFFFF, 16'hFFFF);
		send_request(OP_WRITE, 6'd5, 6'd9, 32'h8000_0000, 16'h0);
		send_request(OP_STEP, 6'd0, 6'd0, 32'h0, 16'hFFFF);
		send_request(OP_READ, 6'd0, 6'd0, 32'h0, 16'h0);
		send_request(OP_STEP, 6'd0, 6'd0, 32'h0, 16'h8000);
		send_request(OP_READ, 6'd63, 6'd0, 32'h0, 16'h0);

		// Random, no idling; receiver holds off while requests pile up
		set_grid(6'd5, 6'd3, 16'd300, 16'd65000);
		holdoff_go = 1'b1;
		random_phase(30, 1'b1);
		// Sender mostly idle
		set_grid(6'd0, 6'd7, 16'd0, 16'd0);
		send_idle_pct = 83;
		random_phase(30, 1'b0);
		// Receiver mostly stalled
		set_grid(6'd4, 6'd0, 16'hFFFF, 16'hFFFF);
		send_idle_pct = 0;
		recv_stall_pct = 83;
		random_phase(30, 1'b0);
		// Both idling some
		set_grid(6'd7, 6'd6, GAIN_RST, DAMP_RST);
		send_idle_pct = 21;
		recv_stall_pct = 21;
		random_phase(30, 1'b1);
		// Full grid, one sweep only
		set_grid(6'd63, 6'd63, 16'd2000, 16'd60000);
		send_request(OP_WRITE, 6'd63, 6'd0, 32'h7FFF_FFFF, 16'h0);
		send_request(OP_WRITE, 6'd32, 6'd17, 32'hFFF0_0000, 16'h0);
		send_request(OP_STEP, 6'd0, 6'd0, 32'h0, 16'hFFFF);
		send_request(OP_READ, 6'd63, 6'd0, 32'h0, 16'h0);
		send_request(OP_READ, 6'd62, 6'd0, 32'h0, 16'h0);
		send_request(OP_READ, 6'd32, 6'd18, 32'h0, 16'h0);

		drain();
		$display("Sent %0d requests: %0d sweeps, %0d height reads, grids from 1x1 to 64x64,",
			sent, steps_done, reads_done);
		$display("under free flow, sender gaps, receiver stalls and a long receiver hold-off.");
		if (failures == 0 && pending == 0) begin
			$display("heightfield_wave_step regression: pass");
		end else begin
			$display("heightfield_wave_step regression: fail");
		end
		$finish;
	end
endmodule

FILE: filelist.f
rtl/core/hws_pkg.sv
rtl/core/hws_mem.sv
rtl/core/hws_point.sv
rtl/core/heightfield_wave_step.sv
tb/hws_checker.sv
tb/tb_top.sv
